FILE: design/modbus_rtu_read_response_parser_assert.svh
// Assertion macros for the Modbus RTU read response parser.
// Included by the checker module; depends on nothing else.
`ifndef MODBUS_RTU_READ_RESPONSE_PARSER_ASSERT_SVH
`define MODBUS_RTU_READ_RESPONSE_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define MRRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define MRRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/mrrp_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the
// Modbus RTU read response parser. No dependencies.
package mrrp_pkg;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  EXC_FLAG     = 8'h80;
   localparam logic [7:0]  SLAVE_MAX    = 8'd247;
   localparam logic [7:0]  FUNC_HOLDING = 8'd3;
   localparam logic [7:0]  FUNC_INPUT   = 8'd4;
   localparam logic [8:0]  POS_MAX      = 9'd511;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_SLAVE    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_FUNCTION = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_START    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_QUANTITY = 2'd3;

   typedef enum logic [3:0] {
      STATUS_OK               = 4'd0,
      STATUS_SHORT_FRAME      = 4'd1,
      STATUS_CRC              = 4'd2,
      STATUS_SHORT_BODY       = 4'd3,
      STATUS_BAD_SETTINGS     = 4'd4,
      STATUS_SLAVE            = 4'd5,
      STATUS_EXCEPTION_LENGTH = 4'd6,
      STATUS_DEVICE_EXCEPTION = 4'd7,
      STATUS_FUNCTION         = 4'd8,
      STATUS_COUNT_LENGTH     = 4'd9,
      STATUS_ODD_COUNT        = 4'd10,
      STATUS_QUANTITY         = 4'd11,
      STATUS_RANGE            = 4'd12
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        is_verdict;
      logic [15:0] reg_address;
      logic [15:0] reg_value;
      status_type  status;
      logic [7:0]  exception_code;
      logic [7:0]  slave_seen;
      logic [7:0]  function_seen;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  expected_slave;
      logic [7:0]  expected_function;
      logic [15:0] expected_start;
      logic [7:0]  expected_quantity;
   } csr_type;

   // Frame summary as it stands once the current byte is taken into account.
   typedef struct packed {
      logic [9:0] length;
      logic       crc_zero;
      logic [7:0] slave_byte;
      logic [7:0] function_byte;
      logic [7:0] count_byte;
   } frame_type;

   typedef struct packed {
      logic        fire;
      logic [15:0] reg_address;
      logic [15:0] reg_value;
   } obs_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: design/mrrp_csr.sv
// Configuration registers of the Modbus RTU read response parser.
// Depends on mrrp_pkg.
module mrrp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [mrrp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrrp_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output mrrp_pkg::csr_type                    cfg
);

   mrrp_pkg::csr_type cfg_ff;
   mrrp_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mrrp_pkg::CSR_EXPECTED_SLAVE:    cfg_in.expected_slave    = csr_write_data[7:0];
            mrrp_pkg::CSR_EXPECTED_FUNCTION: cfg_in.expected_function = csr_write_data[7:0];
            mrrp_pkg::CSR_EXPECTED_START:    cfg_in.expected_start    = csr_write_data[15:0];
            mrrp_pkg::CSR_EXPECTED_QUANTITY: cfg_in.expected_quantity = csr_write_data[7:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_slave    <= 8'd1;
         cfg_ff.expected_function <= mrrp_pkg::FUNC_HOLDING;
         cfg_ff.expected_start    <= 16'd0;
         cfg_ff.expected_quantity <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/mrrp_frame.sv
// Per-frame state of the parser: byte position, running CRC, captured header
// bytes and the held high payload byte. Depends on mrrp_pkg.
module mrrp_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  mrrp_pkg::req_type   req_item,
   input  logic [15:0]         expected_start,
   output mrrp_pkg::frame_type frame,
   output mrrp_pkg::obs_type   obs
);

   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  hold_ff;
   logic [15:0] crc_next;
   logic [7:0]  obs_index;

   assign crc_next = mrrp_pkg::crc_update(crc_ff, req_item.data_byte);

   // Header bytes as seen including the current byte.
   always_comb begin
      slave_in = (pos_ff == 9'd0) ? req_item.data_byte : slave_ff;
      func_in  = (pos_ff == 9'd1) ? req_item.data_byte : func_ff;
      count_in = (pos_ff == 9'd2) ? req_item.data_byte : count_ff;
      pos_in   = (pos_ff == mrrp_pkg::POS_MAX) ? pos_ff : pos_ff + 9'd1;
      crc_in   = crc_next;
   end

   always_comb begin
      frame.length        = {1'b0, pos_ff} + 10'd1;
      frame.crc_zero      = (crc_next == 16'h0000);
      frame.slave_byte    = slave_in;
      frame.function_byte = func_in;
      frame.count_byte    = count_in;
   end

   // Every even position from four on closes a register value.
   assign obs_index = pos_ff[8:1] - 8'd2;

   always_comb begin
      obs.fire        = !req_item.last_byte && (pos_ff >= 9'd4) &&
                        (pos_ff != mrrp_pkg::POS_MAX) && !pos_ff[0];
      obs.reg_address = expected_start + {8'h00, obs_index};
      obs.reg_value   = {hold_ff, req_item.data_byte};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 9'd0;
         crc_ff   <= mrrp_pkg::CRC_INIT;
         slave_ff <= 8'd0;
         func_ff  <= 8'd0;
         count_ff <= 8'd0;
         hold_ff  <= 8'd0;
      end else if (accept) begin
         if (req_item.last_byte) begin
            pos_ff   <= 9'd0;
            crc_ff   <= mrrp_pkg::CRC_INIT;
            slave_ff <= 8'd0;
            func_ff  <= 8'd0;
            count_ff <= 8'd0;
            hold_ff  <= 8'd0;
         end else begin
            pos_ff   <= pos_in;
            crc_ff   <= crc_in;
            slave_ff <= slave_in;
            func_ff  <= func_in;
            count_ff <= count_in;
            hold_ff  <= req_item.data_byte;
         end
      end
   end

endmodule

FILE: design/mrrp_verdict.sv
// Ordered frame checks that produce the verdict item at the final byte.
// Depends on mrrp_pkg.
module mrrp_verdict (
   input  mrrp_pkg::frame_type frame,
   input  mrrp_pkg::csr_type   cfg,
   output mrrp_pkg::rsp_type   verdict
);

   logic        settings_bad;
   logic [16:0] end_address;
   logic [9:0]  body_count;

   assign settings_bad = (cfg.expected_slave == 8'd0) ||
                         (cfg.expected_slave > mrrp_pkg::SLAVE_MAX) ||
                         ((cfg.expected_function != mrrp_pkg::FUNC_HOLDING) &&
                          (cfg.expected_function != mrrp_pkg::FUNC_INPUT)) ||
                         (cfg.expected_quantity == 8'd0);

   assign end_address = {1'b0, cfg.expected_start} + {9'd0, cfg.expected_quantity} - 17'd1;
   assign body_count  = frame.length - 10'd5;

   always_comb begin
      verdict                = '0;
      verdict.is_verdict     = 1'b1;
      verdict.slave_seen     = frame.slave_byte;
      verdict.function_seen  = frame.function_byte;
      verdict.status         = mrrp_pkg::STATUS_OK;
      if (frame.length < 10'd4) begin
         verdict.status = mrrp_pkg::STATUS_SHORT_FRAME;
      end else if (!frame.crc_zero) begin
         verdict.status = mrrp_pkg::STATUS_CRC;
      end else if (frame.length < 10'd5) begin
         verdict.status = mrrp_pkg::STATUS_SHORT_BODY;
      end else if (settings_bad) begin
         verdict.status = mrrp_pkg::STATUS_BAD_SETTINGS;
      end else if (frame.slave_byte != cfg.expected_slave) begin
         verdict.status = mrrp_pkg::STATUS_SLAVE;
      end else if (frame.function_byte == (cfg.expected_function | mrrp_pkg::EXC_FLAG)) begin
         if (frame.length != 10'd5) begin
            verdict.status = mrrp_pkg::STATUS_EXCEPTION_LENGTH;
         end else begin
            verdict.status         = mrrp_pkg::STATUS_DEVICE_EXCEPTION;
            verdict.exception_code = frame.count_byte;
         end
      end else if (frame.function_byte != cfg.expected_function) begin
         verdict.status = mrrp_pkg::STATUS_FUNCTION;
      end else if ({2'b00, frame.count_byte} != body_count) begin
         verdict.status = mrrp_pkg::STATUS_COUNT_LENGTH;
      end else if (frame.count_byte[0]) begin
         verdict.status = mrrp_pkg::STATUS_ODD_COUNT;
      end else if ({1'b0, frame.count_byte[7:1]} != cfg.expected_quantity) begin
         verdict.status = mrrp_pkg::STATUS_QUANTITY;
      end else if (end_address[16]) begin
         verdict.status = mrrp_pkg::STATUS_RANGE;
      end
   end

endmodule

FILE: design/mrrp_out_stage.sv
// Result register of the parser with its valid/stall handshake.
// Depends on mrrp_pkg.
module mrrp_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mrrp_pkg::rsp_type load_item,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output mrrp_pkg::rsp_type rsp_payload,
   output logic              blocked
);

   logic              valid_ff;
   mrrp_pkg::rsp_type payload_ff;

   // The register is full and its item is not taken in this cycle.
   assign blocked = valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= load_item;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

FILE: design/modbus_rtu_read_response_parser.sv
// Modbus RTU read response parser, top level.
// Depends on mrrp_pkg, mrrp_csr, mrrp_frame, mrrp_verdict and mrrp_out_stage.
//
// The request channel carries the bytes of a read response (function 3 or 4)
// in wire order, one item per byte, with last_byte set on the final byte.
// The parser runs CRC-16/MODBUS over every byte and captures the slave id,
// function code and byte count. Each second payload byte that is not the
// final byte produces a tentative register item with its address and value.
// The final byte produces a verdict item with the status of the ordered
// checks. Tentative items must be discarded unless the verdict status is ok.
// Other bytes produce no item.
//
// An item is accepted in every cycle unless the request channel is stalled; the
// result appears in the result register in the cycle after its byte is accepted.
// The byte CRC update and check chain sit between frame state and that register.
// When the receiver stalls while a result is waiting, the request channel is
// stalled in the same cycle; otherwise bytes keep flowing.
// Reset clears the frame state and the result valid flag and loads the
// configuration registers with slave 1, function 3, start 0 and quantity 1.
// Configuration should be written only while no frame is in progress.
module modbus_rtu_read_response_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  mrrp_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output mrrp_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_write_enable,
   input  logic [mrrp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mrrp_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   mrrp_pkg::csr_type   cfg;
   mrrp_pkg::frame_type frame;
   mrrp_pkg::obs_type   obs;
   mrrp_pkg::rsp_type   verdict;
   mrrp_pkg::rsp_type   result;
   logic                accept;
   logic                out_blocked;

   // Input is held off only while a finished result is waiting and stalled.
   assign req_stall = out_blocked;
   assign accept    = req_valid && !req_stall;

   mrrp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   mrrp_frame u_frame (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_item       (req_payload),
      .expected_start (cfg.expected_start),
      .frame          (frame),
      .obs            (obs)
   );

   mrrp_verdict u_verdict (
      .frame   (frame),
      .cfg     (cfg),
      .verdict (verdict)
   );

   // A tentative register item carries zeros in the verdict fields.
   always_comb begin
      if (req_payload.last_byte) begin
         result = verdict;
      end else begin
         result             = '0;
         result.is_verdict  = 1'b0;
         result.reg_address = obs.reg_address;
         result.reg_value   = obs.reg_value;
         result.status      = mrrp_pkg::STATUS_OK;
      end
   end

   mrrp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && (req_payload.last_byte || obs.fire)),
      .load_item   (result),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .blocked     (out_blocked)
   );

endmodule

FILE: design/mrrp_checker.sv
// Port-level checker for the Modbus RTU read response parser, bound to the
// top level. Depends on mrrp_pkg and modbus_rtu_read_response_parser_assert.svh.
`include "modbus_rtu_read_response_parser_assert.svh"

module mrrp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mrrp_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mrrp_pkg::rsp_type rsp_payload
);

   // A stalled result stays in place.
   `MRRP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // Input is stalled only when a waiting result is stalled.
   `MRRP_ASSERT_IMP(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a blocked result")

   // A final byte yields a verdict in the next cycle.
   `MRRP_ASSERT_NXT(a_verdict_follows, clock, reset, req_valid && !req_stall && req_payload.last_byte, rsp_valid && rsp_payload.is_verdict, "final byte gave no verdict")

   // No result appears without an accepted byte.
   `MRRP_ASSERT_NXT(a_no_invented, clock, reset, !(req_valid && !req_stall) && !(rsp_valid && rsp_stall), !rsp_valid, "result without an accepted byte")

   // The exception code is nonzero only on a device exception verdict.
   `MRRP_ASSERT_IMP(a_exception_code, clock, reset, rsp_valid && (rsp_payload.status != mrrp_pkg::STATUS_DEVICE_EXCEPTION), rsp_payload.exception_code == 8'd0, "exception code outside device exception")

endmodule

bind modbus_rtu_read_response_parser mrrp_checker u_checker (.*);

FILE: bench/modbus_rtu_read_response_parser_tb.sv
// Self-checking testbench for the Modbus RTU read response parser.
// Depends on mrrp_pkg for the item, result and register types and the codes.
// A table of directed frames runs first, then random frames under random settings.
module modbus_rtu_read_response_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrrp_pkg::*;

   localparam int NUM_DIRECTED  = 24;
   localparam int RANDOM_PHASES = 5;
   localparam int RANDOM_BYTES  = 200;
   localparam int MAX_GAP       = 10;
   localparam int LONG_HOLD     = 80;
   localparam int QUIET_LIMIT   = 1000;
   localparam int IDLE_SETTLE   = 4;
   localparam int END_SETTLE    = 10;

   localparam csr_type RESET_SETTINGS = '{8'd1, 8'd3, 16'h0000, 8'd1};

   // How a generated frame ends: no CRC bytes at all, a correct CRC, or a CRC
   // with its low byte corrupted.
   typedef enum logic [1:0] {TAIL_NONE, TAIL_GOOD, TAIL_BAD} tail_type;

   // One row of the directed table. The header bytes are slave, function and
   // count; bytes past the count up to head_len are random payload. Where pinned
   // is set, the verdict status is the one typed into the row.
   typedef struct {
      csr_type     setting;
      logic [7:0]  slave_id;
      logic [7:0]  func_code;
      logic [7:0]  count;
      int unsigned head_len;
      tail_type    tail;
      logic        pinned;
      status_type  want;
   } frame_plan_type;

   frame_plan_type directed_plan [NUM_DIRECTED] = '{
      // Frames too short to carry a CRC, a bare body, a corrupted CRC and a good frame.
      '{RESET_SETTINGS, 8'hFF, 8'h00, 8'h00, 1, TAIL_NONE, 1'b1, STATUS_SHORT_FRAME},
      '{RESET_SETTINGS, 8'h00, 8'h03, 8'h00, 3, TAIL_NONE, 1'b1, STATUS_SHORT_FRAME},
      '{RESET_SETTINGS, 8'h01, 8'h03, 8'h00, 2, TAIL_GOOD, 1'b1, STATUS_SHORT_BODY},
      '{RESET_SETTINGS, 8'h01, 8'h03, 8'h02, 5, TAIL_BAD,  1'b1, STATUS_CRC},
      '{RESET_SETTINGS, 8'h01, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b0, STATUS_OK},
      // Register values outside their legal ranges.
      '{'{8'd0, 8'd3, 16'h0000, 8'd1}, 8'h00, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      '{'{8'd248, 8'd3, 16'h0000, 8'd1}, 8'hF8, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      '{'{8'd255, 8'd3, 16'h0000, 8'd1}, 8'hFF, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      '{'{8'd1, 8'd0, 16'h0000, 8'd1}, 8'h01, 8'h00, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      '{'{8'd1, 8'd255, 16'h0000, 8'd1}, 8'h01, 8'hFF, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      '{'{8'd1, 8'd3, 16'h0000, 8'd0}, 8'h01, 8'h03, 8'h00, 3, TAIL_GOOD, 1'b1,
        STATUS_BAD_SETTINGS},
      // Highest legal slave with the input register function.
      '{'{8'd247, 8'd4, 16'h0000, 8'd1}, 8'hF7, 8'h04, 8'h02, 5, TAIL_GOOD, 1'b0,
        STATUS_OK},
      '{'{8'd247, 8'd4, 16'h0000, 8'd1}, 8'h01, 8'h04, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_SLAVE},
      // Exception responses of the right and the wrong length.
      '{RESET_SETTINGS, 8'h01, 8'h83, 8'h02, 3, TAIL_GOOD, 1'b1, STATUS_DEVICE_EXCEPTION},
      '{RESET_SETTINGS, 8'h01, 8'h83, 8'h0B, 4, TAIL_GOOD, 1'b1, STATUS_EXCEPTION_LENGTH},
      '{'{8'd1, 8'd4, 16'h0000, 8'd1}, 8'h01, 8'h84, 8'hFF, 3, TAIL_GOOD, 1'b1,
        STATUS_DEVICE_EXCEPTION},
      // Function, count, odd count and quantity mismatches.
      '{RESET_SETTINGS, 8'h01, 8'h04, 8'h02, 5, TAIL_GOOD, 1'b1, STATUS_FUNCTION},
      '{RESET_SETTINGS, 8'h01, 8'h03, 8'h04, 5, TAIL_GOOD, 1'b1, STATUS_COUNT_LENGTH},
      '{RESET_SETTINGS, 8'h01, 8'h03, 8'h03, 6, TAIL_GOOD, 1'b1, STATUS_ODD_COUNT},
      '{'{8'd1, 8'd3, 16'h0000, 8'd2}, 8'h01, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b1,
        STATUS_QUANTITY},
      // A register range that runs past the top of the address space, one that just
      // fits, and a longer frame of eight registers from address zero.
      '{'{8'd1, 8'd3, 16'hFFFF, 8'd2}, 8'h01, 8'h03, 8'h04, 7, TAIL_GOOD, 1'b1,
        STATUS_RANGE},
      '{'{8'd1, 8'd3, 16'hFFFF, 8'd1}, 8'h01, 8'h03, 8'h02, 5, TAIL_GOOD, 1'b0,
        STATUS_OK},
      '{'{8'd1, 8'd3, 16'h0000, 8'd8}, 8'h01, 8'h03, 8'h10, 19, TAIL_GOOD, 1'b0,
        STATUS_OK},
      // Largest quantity is legal; its count does not match this short body.
      '{'{8'd247, 8'd4, 16'h1234, 8'd255}, 8'hF7, 8'h04, 8'hFE, 5, TAIL_GOOD, 1'b1,
        STATUS_COUNT_LENGTH}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_payload;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_payload;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   // Shadow of the parser: its registers and its frame state.
   csr_type    settings;
   logic [8:0] frame_pos;
   logic [15:0] frame_crc;
   logic [7:0] frame_slave;
   logic [7:0] frame_function;
   logic [7:0] frame_count;
   logic [7:0] held_byte;

   rsp_type     pending_reports [$];
   logic [7:0]  frame_bytes [$];
   int unsigned error_count;
   int unsigned sent_items;
   int unsigned quiet_cycles;
   logic        steady_tx;
   logic        hold_off_request;

   modbus_rtu_read_response_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // CRC-16/MODBUS, one byte, least significant bit first.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      repeat (8) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_pos      = '0;
      frame_crc      = CRC_INIT;
      frame_slave    = '0;
      frame_function = '0;
      frame_count    = '0;
      held_byte      = '0;
   endfunction

   // The ordered checks made on the final byte. len is the frame length,
   // already saturated at 512 through the byte position.
   function automatic status_type frame_status(input int unsigned len,
                                               output logic [7:0] exc);
      int unsigned last_address;
      exc = '0;
      if (len < 4) return STATUS_SHORT_FRAME;
      if (frame_crc != 16'h0000) return STATUS_CRC;
      if (len < 5) return STATUS_SHORT_BODY;
      if (settings.expected_slave == 8'd0 || settings.expected_slave > SLAVE_MAX ||
          (settings.expected_function != FUNC_HOLDING &&
           settings.expected_function != FUNC_INPUT) ||
          settings.expected_quantity == 8'd0)
         return STATUS_BAD_SETTINGS;
      if (frame_slave != settings.expected_slave) return STATUS_SLAVE;
      // An exception reply echoes the function with its top bit set and
      // carries exactly one code byte.
      if (frame_function == (settings.expected_function | EXC_FLAG)) begin
         if (len != 5) return STATUS_EXCEPTION_LENGTH;
         exc = frame_count;
         return STATUS_DEVICE_EXCEPTION;
      end
      if (frame_function != settings.expected_function) return STATUS_FUNCTION;
      if (int'(frame_count) != len - 5) return STATUS_COUNT_LENGTH;
      if (frame_count[0]) return STATUS_ODD_COUNT;
      if ((frame_count >> 1) != settings.expected_quantity) return STATUS_QUANTITY;
      last_address = int'(settings.expected_start) + int'(settings.expected_quantity) - 1;
      if (last_address > 32'h0000_FFFF) return STATUS_RANGE;
      return STATUS_OK;
   endfunction

   // Advances the shadow by one byte. Returns 1 with the result the parser
   // must produce for it, or 0 when the byte produces none.
   function automatic logic parse_byte(input req_type item, output rsp_type report);
      logic [8:0]  pos;
      logic [7:0]  exc;
      int unsigned index;
      pos    = frame_pos;
      report = '0;
      frame_crc = crc16_step(frame_crc, item.data_byte);
      case (pos)
         9'd0: frame_slave    = item.data_byte;
         9'd1: frame_function = item.data_byte;
         9'd2: frame_count    = item.data_byte;
         default: ;
      endcase
      if (item.last_byte) begin
         report.is_verdict    = 1'b1;
         report.status        = frame_status(int'(pos) + 1, exc);
         report.exception_code = exc;
         report.slave_seen    = frame_slave;
         report.function_seen = frame_function;
         clear_frame();
         return 1'b1;
      end
      if (pos < POS_MAX) frame_pos = pos + 9'd1;
      // The low byte of each register sits at an even position from 4 on.
      if (pos >= 9'd4 && pos < POS_MAX && !pos[0]) begin
         index = (int'(pos) - 3) >> 1;
         report.reg_address = settings.expected_start + 16'(index);
         report.reg_value   = {held_byte, item.data_byte};
         held_byte = item.data_byte;
         return 1'b1;
      end
      held_byte = item.data_byte;
      return 1'b0;
   endfunction

   // Fills frame_bytes: header, random payload, cut to head_len, then the tail.
   function automatic void build_frame(input logic [7:0] slave_id, input logic [7:0] func_code,
                                       input logic [7:0] count, input int unsigned head_len,
                                       input tail_type tail);
      logic [15:0] crc;
      logic [7:0]  b;
      crc = CRC_INIT;
      frame_bytes.delete();
      for (int unsigned i = 0; i < head_len; i++) begin
         b = (i == 0) ? slave_id : (i == 1) ? func_code : (i == 2) ? count : 8'($urandom);
         frame_bytes.insert(frame_bytes.size(), b);
         crc = crc16_step(crc, b);
      end
      if (tail != TAIL_NONE) begin
         // The CRC travels low byte first; a single flipped bit pattern in the
         // low byte always leaves a nonzero residue.
         frame_bytes.insert(frame_bytes.size(),
                            tail == TAIL_BAD ? crc[7:0] ^ 8'($urandom_range(1, 255))
                                             : crc[7:0]);
         frame_bytes.insert(frame_bytes.size(), crc[15:8]);
      end
   endfunction

   // Random frame shaped around the current settings. Most are well formed
   // responses; the rest are exceptions, corrupted or mismatched frames,
   // truncated frames and line noise.
   function automatic void make_random_frame();
      int unsigned kind;
      int unsigned head_len;
      logic [7:0]  slave_id;
      logic [7:0]  func_code;
      logic [7:0]  count;
      tail_type    tail;
      slave_id  = settings.expected_slave;
      func_code = settings.expected_function;
      count     = 8'(2 * int'(settings.expected_quantity));
      head_len  = 3 + count;
      tail      = TAIL_GOOD;
      kind      = $urandom_range(0, 99);
      if (kind < 60) begin
      end else if (kind < 68) begin
         func_code = func_code | EXC_FLAG;
         count     = 8'($urandom);
         head_len  = ($urandom_range(0, 3) == 0) ? 4 : 3;
      end else if (kind < 74) begin
         tail = TAIL_BAD;
      end else if (kind < 79) begin
         slave_id = 8'($urandom);
      end else if (kind < 84) begin
         func_code = 8'($urandom);
      end else if (kind < 90) begin
         count    = 8'($urandom_range(0, 20));
         head_len = 3 + $urandom_range(0, 20);
      end else if (kind < 95) begin
         head_len = $urandom_range(1, 3);
         tail     = $urandom_range(0, 1) ? TAIL_GOOD : TAIL_NONE;
      end else begin
         slave_id  = 8'($urandom);
         func_code = 8'($urandom);
         count     = 8'($urandom);
         head_len  = $urandom_range(1, 12);
         tail      = TAIL_NONE;
      end
      build_frame(slave_id, func_code, count, head_len, tail);
   endfunction

   // Random settings: mostly legal with small quantities so that well formed
   // frames stay short, now and then an illegal value or an edge address.
   function automatic csr_type pick_settings();
      csr_type s;
      case ($urandom_range(0, 7))
         0:       s.expected_slave = 8'd1;
         1:       s.expected_slave = SLAVE_MAX;
         2:       s.expected_slave = 8'($urandom_range(0, 15) == 0 ? 0 : 248);
         default: s.expected_slave = 8'($urandom_range(1, 247));
      endcase
      s.expected_function = $urandom_range(0, 1) ? FUNC_INPUT : FUNC_HOLDING;
      if ($urandom_range(0, 15) == 0) s.expected_function = 8'($urandom);
      case ($urandom_range(0, 3))
         0:       s.expected_start = 16'h0000;
         1:       s.expected_start = 16'hFFFF - 16'($urandom_range(0, 4));
         default: s.expected_start = 16'($urandom);
      endcase
      s.expected_quantity = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      return s;
   endfunction

   // Compares one result taken from the parser with the oldest expectation.
   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (pending_reports.size() == 0) begin
         $error("result item with nothing expected: %h", got);
         error_count++;
         return;
      end
      want = pending_reports.pop_front();
      if (got.is_verdict !== want.is_verdict) begin
         $error("is_verdict: expected %0d, got %0d", want.is_verdict, got.is_verdict);
         error_count++;
      end
      if (got.reg_address !== want.reg_address) begin
         $error("reg_address: expected %h, got %h", want.reg_address, got.reg_address);
         error_count++;
      end
      if (got.reg_value !== want.reg_value) begin
         $error("reg_value: expected %h, got %h", want.reg_value, got.reg_value);
         error_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         error_count++;
      end
      if (got.exception_code !== want.exception_code) begin
         $error("exception_code: expected %h, got %h", want.exception_code,
                got.exception_code);
         error_count++;
      end
      if (got.slave_seen !== want.slave_seen) begin
         $error("slave_seen: expected %h, got %h", want.slave_seen, got.slave_seen);
         error_count++;
      end
      if (got.function_seen !== want.function_seen) begin
         $error("function_seen: expected %h, got %h", want.function_seen, got.function_seen);
         error_count++;
      end
   endtask

   // Offers one byte after a random gap, or none in steady mode, and returns at
   // the edge that takes it. The shadow advances at that same edge, so expectations
   // are queued before the parser can show the matching result in the next cycle.
   task automatic send_byte(input req_type item, input logic pin, input status_type pinned);
      rsp_type     report;
      int unsigned gap;
      gap = steady_tx ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      repeat (gap) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = item;
      do @(posedge clock); while (req_stall);
      if (parse_byte(item, report)) begin
         if (pin && item.last_byte) report.status = pinned;
         pending_reports.insert(pending_reports.size(), report);
      end
      sent_items++;
      if (sent_items % 40 == 0) steady_tx = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_frame(input logic pin, input status_type pinned);
      req_type item;
      foreach (frame_bytes[i]) begin
         item.data_byte = frame_bytes[i];
         item.last_byte = (i == frame_bytes.size() - 1);
         send_byte(item, pin, pinned);
      end
   endtask

   // The sender stops offering, waits for every expected result and then lets the
   // result register drain.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Writes all four registers once the parser is idle. Bits above an 8 bit
   // register's width carry random junk, which the parser must drop.
   task automatic apply_settings(input csr_type s);
      wait_idle();
      write_csr(CSR_EXPECTED_SLAVE,    {8'($urandom), s.expected_slave});
      write_csr(CSR_EXPECTED_FUNCTION, {8'($urandom), s.expected_function});
      write_csr(CSR_EXPECTED_START,    s.expected_start);
      write_csr(CSR_EXPECTED_QUANTITY, {8'($urandom), s.expected_quantity});
      settings = s;
   endtask

   // Result side. Each result gets a random number of stall cycles first;
   // every so often the receiver runs without stalling for a while. On request
   // it holds off for a long stretch so that the parser backs up into its input.
   initial begin : receiver
      int unsigned hold;
      int unsigned taken;
      logic        steady_rx;
      taken     = 0;
      steady_rx = 1'b0;
      rsp_stall = 1'b1;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = steady_rx ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_off_request) begin
            hold = LONG_HOLD;
            hold_off_request = 1'b0;
         end
         @(negedge clock);
         repeat (hold) begin
            rsp_stall = 1'b1;
            @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         check_report(rsp_payload);
         taken++;
         if (taken % 32 == 0) steady_rx = ($urandom_range(0, 3) == 0);
      end
   end

   // Ends a run that hangs: too many cycles in a row without any handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_bytes;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      error_count      = 0;
      sent_items       = 0;
      steady_tx        = 1'b0;
      hold_off_request = 1'b0;
      settings         = RESET_SETTINGS;
      clear_frame();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table. Settings change only between frames, with the parser
      // drained first; pinned rows check the verdict status typed in the row.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].setting != settings) apply_settings(directed_plan[i].setting);
         build_frame(directed_plan[i].slave_id, directed_plan[i].func_code,
                     directed_plan[i].count, directed_plan[i].head_len,
                     directed_plan[i].tail);
         send_frame(directed_plan[i].pinned, directed_plan[i].want);
      end

      // Random frames in phases, each under fresh settings. In the second
      // phase the receiver holds off for a long stretch while bytes keep coming.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(pick_settings());
         if (phase == 1) hold_off_request = 1'b1;
         phase_bytes = 0;
         while (phase_bytes < RANDOM_BYTES / RANDOM_PHASES) begin
            make_random_frame();
            phase_bytes += frame_bytes.size();
            send_frame(1'b0, STATUS_OK);
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
